/* hw/rtl/pss_pkg.sv */
package pss_pkg;

    localparam int COUNT_W = 16;
    localparam int PIX_W   = 8;
    localparam int ABITS_W = 18;
    localparam int ABPIX_W = 19;
    localparam int CFG_W   = 10;
    localparam int CIDX_W  = 3;

    localparam logic [5:0]  MAX_PAD       = 6'd62;
    localparam logic [31:0] TURN_OFF_WORD = 32'h0013_8006;
    localparam logic [31:0] STOP_WORD     = 32'h0000_0000;

    // input operations
    localparam logic [1:0] OP_SYM    = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_A_DONE = 2'd2;
    localparam logic [1:0] OP_B_DONE = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_PIX_ON_A = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LEDS     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BITS     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_PAD_A    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PAD_B    = 3'd4;

    localparam logic [9:0] PIX_ON_A_RST = 10'd3;
    localparam logic [2:0] LEDS_RST     = 3'd3;
    localparam logic [4:0] BITS_RST     = 5'd8;
    localparam logic [PIX_W-1:0]   PIX_RST   = PIX_W'(LEDS_RST * BITS_RST);
    localparam logic [ABITS_W-1:0] ABITS_RST = ABITS_W'(PIX_ON_A_RST * PIX_RST);
    localparam logic [ABPIX_W-1:0] ABPIX_RST = ABPIX_W'((PIX_ON_A_RST + 1) * PIX_RST);

    // result kinds, in the order they go out within one word
    localparam logic [2:0] K_ASYM  = 3'd2;
    localparam logic [2:0] K_APAD  = 3'd3;
    localparam logic [2:0] K_ASTOP = 3'd4;
    localparam logic [2:0] K_BSYM  = 3'd5;
    localparam logic [2:0] K_BPAD  = 3'd6;
    localparam logic [2:0] K_BSTOP = 3'd7;

    typedef struct packed {
        logic       load;
        logic       decide;
        logic       emit;
        logic [2:0] kind;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic cfg_busy;
        logic out_free;
        logic is_sym;
        logic is_end;
        logic consumed;
        logic ge_a1;
        logic pad_a_zero;
        logic pad_a_one;
        logic pad_b_zero;
        logic pad_b_one;
        logic stop_sent;
    } t_stat;

    function automatic logic [5:0] sat_pad(input logic [CFG_W-1:0] v);
        return (v[5:0] > MAX_PAD) ? MAX_PAD : v[5:0];
    endfunction

endpackage

/* hw/rtl/pss_in_if.sv */
interface pss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface

/* hw/rtl/pss_out_if.sv */
interface pss_out_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic [31:0] out_symbol;
    logic        start_a;
    logic        start_b;
    logic [15:0] frame_bits;
    logic        last;

    modport source (output valid, output channel, output out_symbol, output start_a,
                    output start_b, output frame_bits, output last, input ready);
    modport sink   (input valid, input channel, input out_symbol, input start_a,
                    input start_b, input frame_bits, input last, output ready);
endinterface

/* hw/rtl/pixel_stream_splitter_top.sv */
// Pixel stream splitter.
// i_in carries one word per received LED bit symbol (op 0), a frame end (op 1),
// or an output-done notice (op 2 for A, op 3 for B). o_out carries the words
// to transmit, tagged with the destination channel, the start pulses and the
// finished frame bit count; last marks the final word caused by an input word.
// The user must write the configuration through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle; the block itself does not enforce this. The input
// is held off in the cycle after each write while r_pix is recomputed; r_abits and
// r_abpix are registered from r_pix in turn. Each word is registered when taken and
// planned in the decide state; the sequencer then emits its n results (1 for a
// plain symbol, up to 64 at frame end with padding), one result per cycle while the
// output is free, into a single output register. Done notices make no results and
// only pass the decide state. A new word is taken while the last result still waits
// in the output register. A receiver stall holds the sequencer in its current step.
// Reset restores the register defaults (3 pixels on A, 3 LEDs, 8 bits) and
// clears the bit count, padding counters and running flags.
module pixel_stream_splitter_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pss_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [pss_pkg::CFG_W-1:0]  i_cfg_data,
    pss_in_if.sink                     i_in,
    pss_out_if.source                  o_out
);

    pss_pkg::t_cmd  w_cmd;
    pss_pkg::t_stat w_stat;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_in.op),
        .i_symbol     (i_in.symbol),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_channel    (o_out.channel),
        .o_out_symbol (o_out.out_symbol),
        .o_start_a    (o_out.start_a),
        .o_start_b    (o_out.start_b),
        .o_frame_bits (o_out.frame_bits),
        .o_last       (o_out.last)
    );

endmodule

/* hw/rtl/pss_dp.sv */
module pss_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pss_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [pss_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]                 i_op,
    input  logic [31:0]                i_symbol,
    input  pss_pkg::t_cmd              i_cmd,
    output pss_pkg::t_stat             o_stat,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_channel,
    output logic [31:0]                o_out_symbol,
    output logic                       o_start_a,
    output logic                       o_start_b,
    output logic [15:0]                o_frame_bits,
    output logic                       o_last
);

    logic [9:0]                    r_pix_on_a;
    logic [2:0]                    r_leds;
    logic [4:0]                    r_bits;
    logic [pss_pkg::PIX_W-1:0]     r_pix;
    logic [pss_pkg::ABITS_W-1:0]   r_abits;
    logic [pss_pkg::ABPIX_W-1:0]   r_abpix;
    logic                          r_busy;
    logic [5:0]                    r_pad_a;
    logic [5:0]                    r_pad_b;
    logic [pss_pkg::COUNT_W-1:0]   r_bc;
    logic                          r_a_run;
    logic                          r_b_run;
    logic                          r_stop_sent;
    logic                          r_fire_a;
    logic                          r_fire_b;
    logic                          r_ov;
    logic [1:0]                    r_op;
    logic [31:0]                   r_sym;
    logic                          r_chan;
    logic [31:0]                   r_word;
    logic                          r_st_a;
    logic                          r_st_b;
    logic [15:0]                   r_fbits;
    logic                          r_last;

    logic                          w_is_sym;
    logic                          w_is_end;
    logic [pss_pkg::COUNT_W-1:0]   w_inc;
    logic [pss_pkg::COUNT_W-1:0]   w_bc_a;
    logic [pss_pkg::COUNT_W-1:0]   w_bc_b;
    logic                          w_consumed;
    logic                          w_fire_a;
    logic                          w_fire_b;

    assign w_is_sym   = (r_op == pss_pkg::OP_SYM);
    assign w_is_end   = (r_op == pss_pkg::OP_END);
    // saturating bit counter
    assign w_inc      = (&r_bc) ? r_bc : r_bc + 1'b1;
    assign w_consumed = w_is_sym && ({2'b00, r_bc} < r_abits);
    assign w_bc_a     = w_consumed ? w_inc : r_bc;
    assign w_bc_b     = w_is_sym ? w_inc : r_bc;
    assign w_fire_a   = (w_is_sym || w_is_end) && !r_a_run
                        && (w_bc_a >= {8'd0, r_pix});
    assign w_fire_b   = (w_is_sym || w_is_end) && !r_b_run
                        && ({3'd0, w_bc_b} >= r_abpix);

    always_comb begin
        o_stat.cfg_busy   = r_busy;
        o_stat.out_free   = !r_ov || i_ready;
        o_stat.is_sym     = w_is_sym;
        o_stat.is_end     = w_is_end;
        o_stat.consumed   = w_consumed;
        o_stat.ge_a1      = ({2'b00, w_bc_a} >= r_abits);
        o_stat.pad_a_zero = (r_pad_a == 6'd0);
        o_stat.pad_a_one  = (r_pad_a == 6'd1);
        o_stat.pad_b_zero = (r_pad_b == 6'd0);
        o_stat.pad_b_one  = (r_pad_b == 6'd1);
        o_stat.stop_sent  = r_stop_sent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_on_a  <= pss_pkg::PIX_ON_A_RST;
            r_leds      <= pss_pkg::LEDS_RST;
            r_bits      <= pss_pkg::BITS_RST;
            r_pix       <= pss_pkg::PIX_RST;
            r_abits     <= pss_pkg::ABITS_RST;
            r_abpix     <= pss_pkg::ABPIX_RST;
            r_busy      <= 1'b0;
            r_pad_a     <= 6'd0;
            r_pad_b     <= 6'd0;
            r_bc        <= '0;
            r_a_run     <= 1'b0;
            r_b_run     <= 1'b0;
            r_stop_sent <= 1'b0;
            r_fire_a    <= 1'b0;
            r_fire_b    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            // thresholds follow the size registers, two multiplies deep
            r_pix   <= pss_pkg::PIX_W'(r_leds) * pss_pkg::PIX_W'(r_bits);
            r_abits <= pss_pkg::ABITS_W'(r_pix_on_a) * pss_pkg::ABITS_W'(r_pix);
            r_abpix <= (pss_pkg::ABPIX_W'(r_pix_on_a) + 1'b1) * pss_pkg::ABPIX_W'(r_pix);
            r_busy  <= i_cfg_we;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pss_pkg::CFG_PIX_ON_A: r_pix_on_a <= i_cfg_data;
                    pss_pkg::CFG_LEDS:     r_leds     <= i_cfg_data[2:0];
                    pss_pkg::CFG_BITS:     r_bits     <= i_cfg_data[4:0];
                    pss_pkg::CFG_PAD_A:    r_pad_a    <= pss_pkg::sat_pad(i_cfg_data);
                    pss_pkg::CFG_PAD_B:    r_pad_b    <= pss_pkg::sat_pad(i_cfg_data);
                    default: ;
                endcase
            end

            if (i_cmd.decide) begin
                case (r_op)
                    pss_pkg::OP_A_DONE: r_a_run <= 1'b0;
                    pss_pkg::OP_B_DONE: r_b_run <= 1'b0;
                    default: begin
                        if (w_is_sym)
                            r_bc <= w_inc;
                        if (w_fire_a)
                            r_a_run <= 1'b1;
                        if (w_fire_b)
                            r_b_run <= 1'b1;
                    end
                endcase
                r_fire_a <= w_fire_a;
                r_fire_b <= w_fire_b;
            end

            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                case (i_cmd.kind)
                    pss_pkg::K_APAD:  r_pad_a <= r_pad_a - 1'b1;
                    pss_pkg::K_ASTOP: r_stop_sent <= 1'b1;
                    pss_pkg::K_BPAD:  r_pad_b <= r_pad_b - 1'b1;
                    pss_pkg::K_BSTOP: begin
                        // frame end: drop A padding, rearm A stop, restart count
                        r_pad_a     <= 6'd0;
                        r_stop_sent <= 1'b0;
                        r_bc        <= '0;
                    end
                    default: ;
                endcase
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_sym <= i_symbol;
        end
        if (i_cmd.emit) begin
            r_chan  <= (i_cmd.kind >= pss_pkg::K_BSYM);
            r_st_a  <= i_cmd.last && r_fire_a;
            r_st_b  <= i_cmd.last && r_fire_b;
            r_last  <= i_cmd.last;
            r_fbits <= (i_cmd.kind == pss_pkg::K_BSTOP) ? r_bc : 16'd0;
            case (i_cmd.kind)
                pss_pkg::K_ASYM, pss_pkg::K_BSYM: r_word <= r_sym;
                pss_pkg::K_APAD, pss_pkg::K_BPAD: r_word <= pss_pkg::TURN_OFF_WORD;
                default:                          r_word <= pss_pkg::STOP_WORD;
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_channel    = r_chan;
    assign o_out_symbol = r_word;
    assign o_start_a    = r_st_a;
    assign o_start_b    = r_st_b;
    assign o_frame_bits = r_fbits;
    assign o_last       = r_last;

endmodule

/* hw/rtl/pss_ctrl.sv */
module pss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pss_pkg::t_stat i_stat,
    output pss_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_ASYM   = pss_pkg::K_ASYM;
    localparam logic [2:0] S_APAD   = pss_pkg::K_APAD;
    localparam logic [2:0] S_BPAD   = pss_pkg::K_BPAD;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [5:0] r_plan;
    logic [5:0] n_plan;
    logic [2:0] w_phase;
    logic       w_more;
    logic       w_accept;

    // first planned phase at or after start, else idle
    function automatic logic [2:0] first_from(input logic [5:0] plan, input logic [2:0] start);
        logic [2:0] nxt;
        nxt = S_IDLE;
        for (int i = 5; i >= 0; i--) begin
            if (plan[i] && (i >= int'(start)))
                nxt = 3'(i) + S_ASYM;
        end
        return nxt;
    endfunction

    assign w_phase    = r_state - S_ASYM;
    assign w_more     = (first_from(r_plan, w_phase + 3'd1) != S_IDLE) && (w_phase != 3'd5);
    assign o_in_ready = (r_state == S_IDLE) && !i_stat.cfg_busy;
    assign w_accept   = o_in_ready && i_in_valid;

    // results of one word, in output order: A data, A pad, A stop, B data, B pad, B stop
    always_comb begin
        n_plan[0] = i_stat.consumed;
        n_plan[1] = i_stat.is_sym && i_stat.ge_a1 && !i_stat.pad_a_zero;
        n_plan[2] = (i_stat.is_end || (i_stat.is_sym && i_stat.ge_a1)) && !i_stat.stop_sent
                    && (i_stat.pad_a_zero || n_plan[1]);
        n_plan[3] = i_stat.is_sym && !i_stat.consumed;
        n_plan[4] = i_stat.is_end && !i_stat.pad_b_zero;
        n_plan[5] = i_stat.is_end;
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = w_accept;
        o_cmd.decide = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.kind   = r_state;
        o_cmd.last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept)
                    n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = first_from(n_plan, 3'd0);
            end
            default: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_state == S_APAD) begin
                        o_cmd.last = i_stat.pad_a_one && !w_more;
                        if (i_stat.pad_a_one)
                            n_state = first_from(r_plan, w_phase + 3'd1);
                    end else if (r_state == S_BPAD) begin
                        o_cmd.last = i_stat.pad_b_one && !w_more;
                        if (i_stat.pad_b_one)
                            n_state = first_from(r_plan, w_phase + 3'd1);
                    end else begin
                        o_cmd.last = !w_more;
                        n_state    = w_more ? first_from(r_plan, w_phase + 3'd1) : S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plan  <= 6'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE)
                r_plan <= n_plan;
        end
    end

endmodule
